// ===== hdl/calibrated_sample_history_unit_macros.svh =====
// Assertion macros for the calibrated sample history unit.
// Used by the port checker; needs nothing else.
`ifndef CALIBRATED_SAMPLE_HISTORY_UNIT_MACROS_SVH
`define CALIBRATED_SAMPLE_HISTORY_UNIT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define CSH_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define CSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/csh_pkg.sv =====
// Shared types and constants of the calibrated sample history unit.
// No dependencies.
`timescale 1ns / 1ps
package csh_pkg;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [4:0]  MUL_STEPS = 5'd18;
  localparam logic [5:0]  DIV_STEPS = 6'd32;

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_CAL_START = 2'd1,
    CMD_CAL_STOP  = 2'd2,
    CMD_DUMP      = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    REG_SMOOTH = 3'd0,
    REG_OFF    = 3'd1,
    REG_LIN    = 3'd2,
    REG_SQ     = 3'd3,
    REG_GAIN   = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    MS_INNER,
    MS_POLY,
    MS_PROD,
    MS_MIXV,
    MS_MIXA
  } mul_sel_t;

  typedef enum logic [1:0] {
    VS_ZERO,
    VS_CALC,
    VS_MEM
  } val_sel_t;

  typedef struct packed {
    logic [16:0]        smooth;
    logic signed [15:0] off;
    logic signed [15:0] lin;
    logic signed [15:0] sq;
    logic [15:0]        gain;
  } cfg_t;

  typedef struct packed {
    logic     take_in;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     scale;
    logic     avg_upd;
    logic     cal_add;
    logic     cal_start;
    logic     div_start;
    logic     stop_fin;
    logic     rd_req;
    logic     load;
    val_sel_t vsel;
    logic     load_last;
  } ctl_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic calibrating;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/csh_cfg.sv =====
// Configuration register bank on an APB-style port.
// Depends on csh_pkg.
`timescale 1ns / 1ps
module csh_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output csh_pkg::cfg_t cfg
);
  import csh_pkg::*;

  cfg_t cfg_r;
  logic wr_en;
  logic smooth_ok;

  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite & pready;
  assign smooth_ok = (pwdata[16:0] != 17'd0) && (pwdata[16:0] <= ONE_Q16);
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.smooth <= 17'd32768;
      cfg_r.off    <= 16'sd0;
      cfg_r.lin    <= 16'sd4096;
      cfg_r.sq     <= 16'sd0;
      cfg_r.gain   <= 16'd256;
    end else if (wr_en) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_SMOOTH: if (smooth_ok) cfg_r.smooth <= pwdata[16:0];
        REG_OFF:    cfg_r.off  <= pwdata[15:0];
        REG_LIN:    cfg_r.lin  <= pwdata[15:0];
        REG_SQ:     cfg_r.sq   <= pwdata[15:0];
        REG_GAIN:   cfg_r.gain <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_SMOOTH: prdata = {15'd0, cfg_r.smooth};
      REG_OFF:    prdata = {{16{cfg_r.off[15]}}, cfg_r.off};
      REG_LIN:    prdata = {{16{cfg_r.lin[15]}}, cfg_r.lin};
      REG_SQ:     prdata = {{16{cfg_r.sq[15]}}, cfg_r.sq};
      REG_GAIN:   prdata = {16'd0, cfg_r.gain};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/csh_dp.sv =====
// Datapath: serial multiply-accumulate, divider, calibration state,
// history memory and output register. Depends on csh_pkg.
`timescale 1ns / 1ps
module csh_dp #(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  csh_pkg::cfg_t cfg,
  input  csh_pkg::ctl_t ctl,
  output csh_pkg::sts_t sts,
  input  logic [15:0]   in_sample,
  input  logic [1:0]    in_command,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [79:0]   out_tdata,
  output logic [1:0]    out_tuser,
  output logic          out_tlast
);
  import csh_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_POS = AW'(HISTORY_DEPTH - 1);

  logic [1:0]         kind_r;
  logic [15:0]        raw_r;
  logic [16:0]        d_r;
  logic [15:0]        baseline_r;
  logic [31:0]        avg_r;
  logic [31:0]        v_r;
  logic               cal_r;
  logic [31:0]        sum_r;
  logic [15:0]        cnt_r;
  logic [AW-1:0]      wp_r;
  logic [AW-1:0]      rp_r;

  // multiply-accumulate
  logic signed [63:0] mc_r, acc_r;
  logic [17:0]        mp_r;
  logic [4:0]         mcnt_r;
  logic [63:0]        mc_ld, acc_ld;
  logic [17:0]        mp_ld;

  // divider
  logic [31:0]        dq_r;
  logic [15:0]        rem_r;
  logic [5:0]         dcnt_r;
  logic               dneg_r;
  logic [16:0]        rem_sh;
  logic               q_bit;
  logic [15:0]        bl_q;

  // scaling
  logic signed [63:0] prod_adj, q_sh, mix_adj;
  logic [31:0]        v_sat;

  // memory
  logic [31:0]              mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] valid_r;
  logic [31:0]              mem_q_r;
  logic                     mem_vq_r;

  logic               out_valid_r;
  logic [79:0]        out_data_r;
  logic [1:0]         out_user_r;
  logic               out_last_r;
  logic [31:0]        val_out;

  assign sts.mul_busy    = (mcnt_r != 5'd0);
  assign sts.div_busy    = (dcnt_r != 6'd0);
  assign sts.calibrating = cal_r;
  assign sts.out_free    = !out_valid_r || out_tready;

  always_comb begin
    case (ctl.mul_sel)
      MS_INNER: begin
        mc_ld  = {{48{cfg.sq[15]}}, cfg.sq};
        mp_ld  = {d_r[16], d_r};
        acc_ld = {{48{cfg.lin[15]}}, cfg.lin};
      end
      MS_POLY: begin
        mc_ld  = acc_r;
        mp_ld  = {d_r[16], d_r};
        acc_ld = {{48{cfg.off[15]}}, cfg.off};
      end
      MS_PROD: begin
        mc_ld  = acc_r;
        mp_ld  = {2'b00, cfg.gain};
        acc_ld = 64'd0;
      end
      MS_MIXV: begin
        mc_ld  = {{32{v_r[31]}}, v_r};
        mp_ld  = {1'b0, cfg.smooth};
        acc_ld = 64'd0;
      end
      MS_MIXA: begin
        mc_ld  = {{32{avg_r[31]}}, avg_r};
        mp_ld  = {1'b0, ONE_Q16 - cfg.smooth};
        acc_ld = acc_r;
      end
      default: begin
        mc_ld  = 64'd0;
        mp_ld  = 18'd0;
        acc_ld = 64'd0;
      end
    endcase
  end

  // one multiplier bit per cycle, sign bit of the multiplier subtracts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= 5'd0;
    end else if (ctl.mul_start) begin
      mc_r   <= mc_ld;
      mp_r   <= mp_ld;
      acc_r  <= acc_ld;
      mcnt_r <= MUL_STEPS;
    end else if (mcnt_r != 5'd0) begin
      if (mp_r[0]) begin
        acc_r <= (mcnt_r == 5'd1) ? acc_r - mc_r : acc_r + mc_r;
      end
      mc_r   <= {mc_r[62:0], 1'b0};
      mp_r   <= {1'b0, mp_r[17:1]};
      mcnt_r <= mcnt_r - 5'd1;
    end
  end

  // restoring divide of |sum| by count
  assign rem_sh = {rem_r, dq_r[31]};
  assign q_bit  = (rem_sh >= {1'b0, cnt_r});
  assign bl_q   = dneg_r ? 16'(-dq_r[15:0]) : dq_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= 6'd0;
    end else if (ctl.div_start) begin
      dq_r   <= sum_r[31] ? 32'(-sum_r) : sum_r;
      dneg_r <= sum_r[31];
      rem_r  <= 16'd0;
      dcnt_r <= DIV_STEPS;
    end else if (dcnt_r != 6'd0) begin
      rem_r  <= q_bit ? 16'(rem_sh - {1'b0, cnt_r}) : rem_sh[15:0];
      dq_r   <= {dq_r[30:0], q_bit};
      dcnt_r <= dcnt_r - 6'd1;
    end
  end

  // divide by 2^20 toward zero, then saturate
  always_comb begin
    prod_adj = acc_r + (acc_r[63] ? 64'sd1048575 : 64'sd0);
    q_sh     = prod_adj >>> 20;
    if (q_sh > 64'sd2147483647)       v_sat = 32'h7FFF_FFFF;
    else if (q_sh < -64'sd2147483648) v_sat = 32'h8000_0000;
    else                              v_sat = q_sh[31:0];
    mix_adj  = acc_r + (acc_r[63] ? 64'sd65535 : 64'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r <= 16'd0;
      avg_r      <= 32'd0;
      cal_r      <= 1'b0;
      sum_r      <= 32'd0;
      cnt_r      <= 16'd0;
      wp_r       <= '0;
      valid_r    <= '0;
    end else begin
      if (ctl.take_in) begin
        kind_r <= in_command;
        raw_r  <= in_sample;
        d_r    <= {in_sample[15], in_sample} - {baseline_r[15], baseline_r};
        rp_r   <= wp_r;
      end
      if (ctl.cal_start) begin
        cal_r      <= 1'b1;
        sum_r      <= 32'd0;
        cnt_r      <= 16'd0;
        baseline_r <= 16'd0;
      end
      if (ctl.cal_add && (cnt_r != COUNT_MAX)) begin
        sum_r <= sum_r + {{16{raw_r[15]}}, raw_r};
        cnt_r <= cnt_r + 16'd1;
      end
      if (ctl.scale) begin
        v_r           <= v_sat;
        valid_r[wp_r] <= 1'b1;
        wp_r          <= (wp_r == LAST_POS) ? '0 : wp_r + 1'b1;
      end
      if (ctl.avg_upd) begin
        avg_r <= mix_adj[47:16];
      end
      if (ctl.stop_fin) begin
        cal_r      <= 1'b0;
        baseline_r <= (cnt_r == 16'd0) ? 16'd0 : bl_q;
        avg_r      <= 32'd0;
        wp_r       <= '0;
        valid_r    <= '0;
      end
      if (ctl.rd_req) begin
        rp_r <= (rp_r == LAST_POS) ? '0 : rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scale) begin
      mem[wp_r] <= v_sat;
    end
    if (ctl.rd_req) begin
      mem_q_r  <= mem[rp_r];
      mem_vq_r <= valid_r[rp_r];
    end
  end

  always_comb begin
    case (ctl.vsel)
      VS_CALC: val_out = v_r;
      VS_MEM:  val_out = mem_vq_r ? mem_q_r : 32'd0;
      default: val_out = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load) begin
      out_valid_r <= 1'b1;
      out_data_r  <= {baseline_r, avg_r, val_out};
      out_user_r  <= kind_r;
      out_last_r  <= ctl.load_last;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/csh_ctrl.sv =====
// Controller state machine: sequences the datapath for each command word.
// Depends on csh_pkg.
`timescale 1ns / 1ps
module csh_ctrl #(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    in_tuser,
  input  csh_pkg::sts_t sts,
  output csh_pkg::ctl_t ctl
);
  import csh_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_POS = AW'(HISTORY_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CAL, S_START, S_INNER, S_POLY, S_PROD, S_SCALE, S_MIXV,
    S_MIXA, S_AVG, S_DIV, S_STOP, S_RD, S_DLOAD, S_LOAD
  } state_t;

  state_t        state_r;
  logic          started_r;
  logic          calc_r;
  logic [AW-1:0] idx_r;
  logic          accept;
  logic          unit_done;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign unit_done = started_r && !sts.mul_busy && !sts.div_busy;

  always_comb begin
    ctl           = '0;
    ctl.mul_sel   = MS_INNER;
    ctl.vsel      = calc_r ? VS_CALC : VS_ZERO;
    case (state_r)
      S_IDLE:  ctl.take_in = accept;
      S_CAL:   ctl.cal_add = 1'b1;
      S_START: ctl.cal_start = 1'b1;
      S_INNER: ctl.mul_start = !started_r;
      S_POLY: begin
        ctl.mul_start = !started_r;
        ctl.mul_sel   = MS_POLY;
      end
      S_PROD: begin
        ctl.mul_start = !started_r;
        ctl.mul_sel   = MS_PROD;
      end
      S_SCALE: ctl.scale = 1'b1;
      S_MIXV: begin
        ctl.mul_start = !started_r;
        ctl.mul_sel   = MS_MIXV;
      end
      S_MIXA: begin
        ctl.mul_start = !started_r;
        ctl.mul_sel   = MS_MIXA;
      end
      S_AVG:   ctl.avg_upd = 1'b1;
      S_DIV:   ctl.div_start = !started_r;
      S_STOP:  ctl.stop_fin = 1'b1;
      S_RD:    ctl.rd_req = 1'b1;
      S_DLOAD: begin
        ctl.load      = sts.out_free;
        ctl.vsel      = VS_MEM;
        ctl.load_last = (idx_r == LAST_POS);
      end
      S_LOAD: begin
        ctl.load      = sts.out_free;
        ctl.load_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      started_r <= 1'b0;
      calc_r    <= 1'b0;
      idx_r     <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            idx_r <= '0;
            case (cmd_code_t'(in_tuser))
              CMD_SAMPLE: begin
                calc_r  <= !sts.calibrating;
                state_r <= sts.calibrating ? S_CAL : S_INNER;
              end
              CMD_CAL_START: state_r <= S_START;
              CMD_CAL_STOP:  state_r <= S_DIV;
              CMD_DUMP:      state_r <= S_RD;
              default:       state_r <= S_IDLE;
            endcase
          end
        end
        S_CAL, S_START, S_STOP: state_r <= S_LOAD;
        S_INNER, S_POLY, S_PROD, S_MIXV, S_MIXA, S_DIV: begin
          if (!started_r) begin
            started_r <= 1'b1;
          end else if (unit_done) begin
            started_r <= 1'b0;
            case (state_r)
              S_INNER: state_r <= S_POLY;
              S_POLY:  state_r <= S_PROD;
              S_PROD:  state_r <= S_SCALE;
              S_MIXV:  state_r <= S_MIXA;
              S_MIXA:  state_r <= S_AVG;
              default: state_r <= S_STOP;
            endcase
          end
        end
        S_SCALE: state_r <= S_MIXV;
        S_AVG:   state_r <= S_LOAD;
        S_RD:    state_r <= S_DLOAD;
        S_DLOAD: begin
          if (sts.out_free) begin
            if (idx_r == LAST_POS) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        S_LOAD: begin
          if (sts.out_free) begin
            calc_r  <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/calibrated_sample_history_unit.sv =====
// Usage notes
// Input stream: in_tuser carries the command (sample, calibration start,
// calibration stop, history dump), in_tdata the signed 16-bit sample.
// Output stream: one word per sample, start or stop command, and
// HISTORY_DEPTH words per dump, oldest first; out_tlast marks the final
// word of each command. out_tuser echoes the command.
// Sequence: a calibrated sample runs five passes of the shared 18-step
// serial multiplier, each with its launch and finish, plus the scale,
// average and load steps. A stop runs the 32-step divider, then clears
// and loads; a start or a calibrating sample updates the window, then
// loads. A dump reads each word from the history, then loads it.
// One command word is in work at a time; in_tready rises again once its
// last result is in the output register, so the next word can be taken
// while that result waits for out_tready.
// Reset (synchronous, active low) clears the history valid bits, average,
// baseline, calibration state and loads register defaults.
// A stalled receiver holds the output word; the controller waits before
// loading the next one and nothing is dropped.
// Depends on csh_pkg, csh_cfg, csh_dp and csh_ctrl.
`timescale 1ns / 1ps
module calibrated_sample_history_unit #(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [31:0] value, [63:32] average, [79:64] baseline_now
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import csh_pkg::*;

  cfg_t cfg;
  ctl_t ctl;
  sts_t sts;

  // register bank
  csh_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  csh_ctrl #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .ctl       (ctl)
  );

  // arithmetic, history and output word
  csh_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .ctl        (ctl),
    .sts        (sts),
    .in_sample  (in_tdata),
    .in_command (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hdl/csh_checker.sv =====
// Port-level checks for the calibrated sample history unit, bound to it.
// Depends on csh_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "calibrated_sample_history_unit_macros.svh"
module csh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import csh_pkg::*;

  `CSH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output word changed while stalled")
  `CSH_ASSERT_NEXT(a_one_word, clk, rst_n, in_tvalid && in_tready, !in_tready, "second input word taken while one is in work")
  `CSH_ASSERT_ALWAYS(a_single_last, clk, rst_n, !out_tvalid || out_tuser == CMD_DUMP || out_tlast, "single-result command without last")

endmodule

bind calibrated_sample_history_unit csh_checker u_csh_checker (.*);

// ===== verif/tb_calibrated_sample_history_unit.sv =====
// Self-checking testbench for calibrated_sample_history_unit: streams commands,
// mirrors the calibration, history and average in a local predictor and checks
// every output word. Depends on csh_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb_calibrated_sample_history_unit;
  import csh_pkg::*;

  localparam int DEPTH       = 32;
  localparam int SETTLE_CYC  = 150;
  localparam int REG_SPARE   = 5;     // first address past the register list

  typedef struct {
    cmd_code_t          cmd;
    logic signed [15:0] smp;
    bit                 hold;          // wait for every outstanding word first
  } cmd_word_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic signed [31:0] average;
    logic signed [15:0] baseline;
    logic               last;
  } result_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // [15:0] sample
  logic [1:0]  in_tuser = '0;    // [1:0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;        // [31:0] value, [63:32] average, [79:64] baseline_now
  logic [1:0]  out_tuser;        // [1:0] kind
  logic        out_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cmd_word_t    cmd_backlog[$];
  result_word_t pending_results[$];
  int           fail_count = 0;
  logic         in_taken = 1'b0;

  // Predictor copy of registers and state
  logic [16:0]        smooth_q;
  logic signed [15:0] offset_q, linear_q, square_q;
  logic [15:0]        gain_q;
  logic signed [31:0] hist_q[DEPTH];
  logic [4:0]         wpos_q;
  logic signed [31:0] avg_q;
  logic signed [15:0] base_q;
  logic               cal_q;
  int                 cal_sum_q;
  logic [15:0]        cal_cnt_q;

  calibrated_sample_history_unit #(.HISTORY_DEPTH(DEPTH)) u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk = ~clk;

  function automatic void reset_model();
    smooth_q = 17'd32768; offset_q = '0; linear_q = 16'sd4096; square_q = '0;
    gain_q = 16'd256;
    foreach (hist_q[i]) hist_q[i] = '0;
    wpos_q = '0; avg_q = '0; base_q = '0; cal_q = 1'b0; cal_sum_q = 0; cal_cnt_q = '0;
  endfunction

  function automatic void push_result(cmd_code_t c, logic signed [31:0] v, logic lst);
    result_word_t r;
    r.kind = c; r.value = v; r.average = avg_q; r.baseline = base_q; r.last = lst;
    pending_results.push_back(r);
  endfunction

  // Gain-scaled quadratic of (sample - baseline), truncated by 2^20, saturated
  function automatic logic signed [31:0] scale_sample(logic signed [15:0] s);
    longint d, inner, poly, prod, q;
    d     = longint'(s) - longint'(base_q);
    inner = longint'(linear_q) + d * longint'(square_q);
    poly  = longint'(offset_q) + d * inner;
    prod  = poly * longint'({48'd0, gain_q});
    q     = prod / (longint'(1) << 20);
    if (q > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (q < -64'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic void apply_command(cmd_code_t c, logic signed [15:0] s);
    logic signed [31:0] v;
    longint mix, a;
    case (c)
      CMD_SAMPLE: begin
        v = '0;
        if (cal_q) begin
          // drop samples once the window count is full
          if (cal_cnt_q != COUNT_MAX) begin
            cal_sum_q += int'(s);
            cal_cnt_q++;
          end
        end else begin
          v = scale_sample(s);
          hist_q[wpos_q] = v;
          wpos_q++;
          a = longint'({47'd0, smooth_q});
          mix = a * longint'(v) + (64'sd65536 - a) * longint'(avg_q);
          avg_q = 32'(mix / 64'sd65536);
        end
        push_result(c, v, 1'b1);
      end
      CMD_CAL_START: begin
        cal_q = 1'b1; cal_sum_q = 0; cal_cnt_q = '0; base_q = '0;
        push_result(c, '0, 1'b1);
      end
      CMD_CAL_STOP: begin
        cal_q = 1'b0;
        base_q = (cal_cnt_q == '0) ? 16'sd0 : 16'(cal_sum_q / int'({16'd0, cal_cnt_q}));
        foreach (hist_q[i]) hist_q[i] = '0;
        avg_q = '0; wpos_q = '0;
        push_result(c, '0, 1'b1);
      end
      default: begin
        for (int i = 0; i < DEPTH; i++)
          push_result(c, hist_q[5'(wpos_q + i)], i == DEPTH - 1);
      end
    endcase
  endfunction

  function automatic void apply_register(int idx, logic [31:0] data);
    case (idx)
      REG_SMOOTH: if (data[16:0] >= 17'd1 && data[16:0] <= ONE_Q16) smooth_q = data[16:0];
      REG_OFF:    offset_q = data[15:0];
      REG_LIN:    linear_q = data[15:0];
      REG_SQ:     square_q = data[15:0];
      REG_GAIN:   gain_q   = data[15:0];
      default: ;
    endcase
  endfunction

  // Register write: setup cycle, then access cycle; pready is always high
  task automatic write_register(int idx, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 5'(idx * 4); pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    apply_register(idx, data);
  endtask

  task automatic queue_cmd(cmd_code_t c, logic signed [15:0] s = '0, bit h = 1'b0);
    cmd_word_t w;
    w.cmd = c; w.smp = s; w.hold = h;
    cmd_backlog.push_back(w);
  endtask

  // Hold until all words are sent and answered, then let the unit settle
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1, 2:    return 16'($signed($urandom_range(0, 128)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(0, 4))
      0:       return ($urandom & 32'hFFFF0000) | 32'h7FFF;
      1:       return ($urandom & 32'hFFFF0000) | 32'h8000;
      2:       return 32'($signed($urandom_range(0, 8192)) - 4096);
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed traffic: sample runs, short calibration windows, dumps
  task automatic queue_random(int n);
    bit in_cal = 1'b0;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (in_cal) begin
        if (r < 80)      queue_cmd(CMD_SAMPLE, pick_sample());
        else if (r < 93) begin queue_cmd(CMD_CAL_STOP); in_cal = 1'b0; end
        else if (r < 97) queue_cmd(CMD_CAL_START);
        else             queue_cmd(CMD_DUMP);
      end else begin
        if (r < 76)      queue_cmd(CMD_SAMPLE, pick_sample(), i == n / 2);
        else if (r < 84) queue_cmd(CMD_DUMP);
        else if (r < 93) begin queue_cmd(CMD_CAL_START); in_cal = 1'b1; end
        else             queue_cmd(CMD_CAL_STOP);
      end
    end
  endtask

  // Driver: bursts of words separated by random gaps
  always @(negedge clk) begin : drive_cmds
    static int burst_left = 1;
    static int gap_left = 0;
    cmd_word_t w;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (cmd_backlog.size() != 0 &&
                   !(cmd_backlog[0].hold && pending_results.size() != 0)) begin
        w = cmd_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= w.cmd;
        in_tdata  <= w.smp;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: rotate between always ready, random stalls and a fixed stall pattern
  always @(negedge clk) begin : drive_ready
    static int cyc = 0;
    cyc++;
    case ((cyc / 257) % 3)
      0:       out_tready <= 1'b1;
      1:       out_tready <= $urandom_range(0, 2) != 0;
      default: out_tready <= (cyc % 7) > 2;
    endcase
  end

  // Predict on each accepted command, check each accepted result
  always @(posedge clk) begin : check_results
    result_word_t e;
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      apply_command(cmd_code_t'(in_tuser), in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word kind=%0d value=%0d", out_tuser,
               $signed(out_tdata[31:0]));
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_tuser !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_tuser); fail_count++;
        end
        if (out_tdata[31:0] !== e.value) begin
          $error("value: expected %0d, got %0d", e.value, $signed(out_tdata[31:0]));
          fail_count++;
        end
        if (out_tdata[63:32] !== e.average) begin
          $error("average: expected %0d, got %0d", e.average, $signed(out_tdata[63:32]));
          fail_count++;
        end
        if (out_tdata[79:64] !== e.baseline) begin
          $error("baseline_now: expected %0d, got %0d", e.baseline,
                 $signed(out_tdata[79:64]));
          fail_count++;
        end
        if (out_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_tlast); fail_count++;
        end
      end
    end
  end

  initial begin
    reset_model();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, restart while calibrating, stops with and without samples
    queue_cmd(CMD_SAMPLE, 16'sd0);
    queue_cmd(CMD_SAMPLE, 16'sh7FFF);
    queue_cmd(CMD_SAMPLE, 16'sh8000);
    queue_cmd(CMD_SAMPLE, 16'sd1);
    queue_cmd(CMD_CAL_STOP);                  // stop outside a window
    queue_cmd(CMD_CAL_START);
    queue_cmd(CMD_SAMPLE, 16'sd100);
    queue_cmd(CMD_SAMPLE, -16'sd33);
    queue_cmd(CMD_CAL_START);                 // restart drops the partial window
    queue_cmd(CMD_SAMPLE, -16'sd300);
    queue_cmd(CMD_SAMPLE, -16'sd301);
    queue_cmd(CMD_CAL_STOP);                  // truncating mean toward zero
    queue_cmd(CMD_SAMPLE, 16'sh7FFF);
    queue_cmd(CMD_SAMPLE, 16'sh8000);
    queue_cmd(CMD_DUMP);
    queue_cmd(CMD_CAL_STOP);                  // recompute from the kept sum
    queue_cmd(CMD_CAL_START);
    queue_cmd(CMD_CAL_STOP);                  // empty window gives zero baseline
    queue_cmd(CMD_SAMPLE, 16'sd5);
    queue_cmd(CMD_SAMPLE, -16'sd5);
    queue_cmd(CMD_DUMP);
    wait_idle();

    // Saturating corner of the polynomial, no smoothing
    write_register(REG_SMOOTH, 32'h0001_0000);
    write_register(REG_OFF,    32'h0000_7FFF);
    write_register(REG_LIN,    32'hFFFF_8000);
    write_register(REG_SQ,     32'h0000_7FFF);
    write_register(REG_GAIN,   32'h0000_FFFF);
    queue_cmd(CMD_SAMPLE, 16'sh7FFF);
    queue_cmd(CMD_SAMPLE, 16'sh8000);
    queue_cmd(CMD_SAMPLE, 16'sd0);
    queue_cmd(CMD_DUMP);
    wait_idle();

    // Heaviest smoothing, zero gain, out-of-range writes ignored
    write_register(REG_SMOOTH, 32'h0000_0001);
    write_register(REG_SMOOTH, 32'h0000_0000);
    write_register(REG_SMOOTH, 32'hFFFF_FFFF);
    write_register(REG_SPARE,  32'h0000_1234);
    write_register(REG_SQ,     32'hFFFF_8000);
    write_register(REG_GAIN,   32'h0000_0000);
    queue_cmd(CMD_SAMPLE, 16'sh7FFF);
    queue_cmd(CMD_SAMPLE, 16'sh8000);
    wait_idle();
    write_register(REG_GAIN, 32'h0000_FFFF);
    queue_cmd(CMD_SAMPLE, 16'sh8000);
    queue_cmd(CMD_SAMPLE, 16'sh7FFF);
    queue_cmd(CMD_DUMP);
    wait_idle();

    // Random traffic under several register settings
    for (int seg = 0; seg < 4; seg++) begin
      write_register(REG_SMOOTH, ($urandom & 32'hFFFE_0000) |
                     ((seg == 1) ? 32'd1 : (seg == 2) ? 32'd65536 : $urandom_range(1, 65536)));
      write_register(REG_OFF,  pick_coeff());
      write_register(REG_LIN,  pick_coeff());
      write_register(REG_SQ,   (seg == 0) ? 32'd0 : pick_coeff());
      write_register(REG_GAIN, $urandom);
      queue_random(72);
      wait_idle();
    end

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #12ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
